/* rtl/core/cnu_pkg.sv */
// Package for the combinatorial number unit.
// Holds request and status codes, sequencer state type and datapath widths.
// No dependencies.
package cnu_pkg;

  localparam int VAL_W = 64;
  localparam int FAC_W = 5;

  typedef enum logic [2:0] {
    REQ_POW   = 3'd0,
    REQ_ARR   = 3'd1,
    REQ_PERM  = 3'd2,
    REQ_COMB  = 3'd3,
    REQ_STIR  = 3'd4,
    REQ_BELL  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVF     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ROW_INIT,
    S_ROW_RD,
    S_ROW_EX,
    S_ROW_END,
    S_FIN_RD,
    S_FIN_EX,
    S_DONE
  } state_t;

endpackage

/* rtl/core/combinatorial_number_unit_top.sv */
// Combinatorial number unit: powers, arrangements, factorials, combinations,
// Stirling numbers of the second kind and Bell numbers on one shared
// multiply-add unit. Depends on cnu_pkg.
//
// Usage: an item (req_type, operand_n, operand_k) enters on in_valid/in_ready.
// The block takes one item at a time; in_ready is high only while idle. Each
// item gives one result (value, status) on out_valid/out_ready, held until
// taken; the block stays busy while the receiver stalls.
// Power, arrangements and permutations run one 64x5 multiply per cycle.
// Combinations and Stirling numbers build a triangle in the scratch row; each
// entry is a registered memory read, then a multiply-add and write back. Bell
// numbers add a sum over the row.
// Reset: synchronous, returns the sequencer to idle with no result pending.
// The scratch row needs no clearing; every entry read was written by the
// same item.
module combinatorial_number_unit_top #(
  parameter int MAX_N = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [4:0]  operand_n,
  input  logic [4:0]  operand_k,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [1:0]  status
);

  localparam int DEPTH = MAX_N + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int VW    = cnu_pkg::VAL_W;
  localparam int FW    = cnu_pkg::FAC_W;

  cnu_pkg::state_t state, state_next;

  logic [2:0]    rtype;
  logic [4:0]    n, k, i, j, cnt, fac;
  logic [VW-1:0] acc;
  logic          acc_ovf;
  logic [VW:0]   cur;
  logic [VW:0]   mem_q;
  logic [VW:0]   mem [DEPTH];

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [VW:0]   wd;

  logic [VW-1:0]     ua, ub;
  logic [FW-1:0]     uf;
  logic              ufin;
  logic [VW+FW-1:0]  prod;
  logic [VW+FW:0]    sum;
  logic              uovf;
  logic [VW-1:0]     usum;

  logic bad_in, is_stir, is_bell;

  assign bad_in = (32'(operand_n) > 32'(MAX_N)) || (req_type > cnu_pkg::REQ_BELL) ||
                  (((req_type == cnu_pkg::REQ_ARR) || (req_type == cnu_pkg::REQ_COMB))
                   && (operand_k > operand_n));
  assign is_stir = (rtype == cnu_pkg::REQ_STIR) || (rtype == cnu_pkg::REQ_BELL);
  assign is_bell = (rtype == cnu_pkg::REQ_BELL);

  // shared multiply-add with overflow: a * f + b
  always_comb begin
    ua   = acc;
    uf   = fac;
    ub   = '0;
    ufin = acc_ovf;
    case (state)
      cnu_pkg::S_ROW_EX: begin
        ua   = cur[VW-1:0];
        uf   = is_stir ? j : FW'(1);
        ub   = mem_q[VW-1:0];
        ufin = cur[VW] | mem_q[VW];
      end
      cnu_pkg::S_FIN_EX: begin
        ua   = mem_q[VW-1:0];
        uf   = FW'(1);
        ub   = acc;
        ufin = mem_q[VW] | acc_ovf;
      end
      default: begin
        ua = acc;
      end
    endcase
  end

  assign prod = {{FW{1'b0}}, ua} * {{VW{1'b0}}, uf};
  assign sum  = {1'b0, prod} + {{(FW+1){1'b0}}, ub};
  assign uovf = ufin | (|sum[VW+FW:VW]);
  assign usum = sum[VW-1:0];

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    re = 1'b0;
    ra = '0;
    case (state)
      cnu_pkg::S_ROW_INIT: begin
        we = 1'b1;
        wd = {1'b0, VW'(1)};
      end
      cnu_pkg::S_ROW_RD: begin
        re = 1'b1;
        ra = AW'(j - 5'd1);
      end
      cnu_pkg::S_ROW_EX: begin
        we = 1'b1;
        wa = AW'(j);
        wd = uovf ? {1'b1, {VW{1'b0}}} : {1'b0, usum};
      end
      cnu_pkg::S_ROW_END: begin
        we = is_stir;
      end
      cnu_pkg::S_FIN_RD: begin
        re = 1'b1;
        ra = is_bell ? AW'(i) : AW'(k);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) mem_q <= mem[ra];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cnu_pkg::S_IDLE: begin
        if (in_valid) begin
          if (bad_in) state_next = cnu_pkg::S_DONE;
          else if (req_type inside {cnu_pkg::REQ_POW, cnu_pkg::REQ_ARR, cnu_pkg::REQ_PERM})
            state_next = cnu_pkg::S_MUL;
          else if ((req_type == cnu_pkg::REQ_STIR) && (operand_k > operand_n))
            state_next = cnu_pkg::S_DONE;
          else state_next = cnu_pkg::S_ROW_INIT;
        end
      end
      cnu_pkg::S_MUL:      if (cnt == 5'd0) state_next = cnu_pkg::S_DONE;
      cnu_pkg::S_ROW_INIT: state_next = (n == 5'd0) ? cnu_pkg::S_FIN_RD : cnu_pkg::S_ROW_RD;
      cnu_pkg::S_ROW_RD:   state_next = cnu_pkg::S_ROW_EX;
      cnu_pkg::S_ROW_EX:   state_next = (j == 5'd1) ? cnu_pkg::S_ROW_END : cnu_pkg::S_ROW_RD;
      cnu_pkg::S_ROW_END:  state_next = (i == n) ? cnu_pkg::S_FIN_RD : cnu_pkg::S_ROW_RD;
      cnu_pkg::S_FIN_RD:   state_next = cnu_pkg::S_FIN_EX;
      cnu_pkg::S_FIN_EX: begin
        if (!is_bell || (i == n)) state_next = cnu_pkg::S_DONE;
        else state_next = cnu_pkg::S_FIN_RD;
      end
      cnu_pkg::S_DONE:     if (out_ready) state_next = cnu_pkg::S_IDLE;
      default:             state_next = cnu_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state == cnu_pkg::S_IDLE);
    out_valid = (state == cnu_pkg::S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cnu_pkg::S_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      cnu_pkg::S_IDLE: begin
        rtype   <= req_type;
        n       <= operand_n;
        k       <= operand_k;
        acc     <= VW'(1);
        acc_ovf <= 1'b0;
        fac     <= operand_n;
        cnt     <= (req_type == cnu_pkg::REQ_PERM) ?
                   ((operand_n >= 5'd2) ? operand_n - 5'd1 : 5'd0) : operand_k;
        value   <= '0;
        status  <= bad_in ? cnu_pkg::ST_INVALID : cnu_pkg::ST_OK;
      end
      cnu_pkg::S_MUL: begin
        if (cnt == 5'd0) begin
          value  <= acc_ovf ? '0 : acc;
          status <= acc_ovf ? cnu_pkg::ST_OVF : cnu_pkg::ST_OK;
        end else begin
          acc     <= usum;
          acc_ovf <= uovf;
          cnt     <= cnt - 5'd1;
          if (rtype != cnu_pkg::REQ_POW) fac <= fac - 5'd1;
        end
      end
      cnu_pkg::S_ROW_INIT: begin
        i       <= (n == 5'd0) ? 5'd0 : 5'd1;
        j       <= 5'd1;
        cur     <= '0;
        acc     <= '0;
        acc_ovf <= 1'b0;
      end
      cnu_pkg::S_ROW_EX: begin
        cur <= mem_q;
        j   <= j - 5'd1;
      end
      cnu_pkg::S_ROW_END: begin
        cur <= '0;
        if (i == n) begin
          i <= 5'd0;
        end else begin
          i <= i + 5'd1;
          j <= i + 5'd1;
        end
      end
      cnu_pkg::S_FIN_EX: begin
        if (is_bell) begin
          acc     <= usum;
          acc_ovf <= uovf;
          i       <= i + 5'd1;
          if (i == n) begin
            value  <= uovf ? '0 : usum;
            status <= uovf ? cnu_pkg::ST_OVF : cnu_pkg::ST_OK;
          end
        end else begin
          value  <= mem_q[VW] ? '0 : mem_q[VW-1:0];
          status <= mem_q[VW] ? cnu_pkg::ST_OVF : cnu_pkg::ST_OK;
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != cnu_pkg::ST_OK)) |-> (value == '0))
    else $error("nonzero value with error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == cnu_pkg::ST_OK || status == cnu_pkg::ST_OVF ||
                   status == cnu_pkg::ST_INVALID))
    else $error("unused status code");

endmodule

/* verif/combinatorial_number_unit_top_test.sv */
// Testbench for combinatorial_number_unit_top: directed table, then random requests,
// each result checked against an in-bench predictor under varied idle patterns.
// Depends on cnu_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module combinatorial_number_unit_top_test;

  typedef struct {
    logic [2:0]  kind;
    logic [4:0]  n;
    logic [4:0]  k;
    bit          known;
    logic [63:0] val;
    logic [1:0]  st;
  } request_row_t;

  typedef struct {
    logic [63:0] val;
    logic [1:0]  st;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [4:0]  operand_n = '0;
  logic [4:0]  operand_k = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] value;
  logic [1:0]  status;

  answer_t answers_pending[$];
  int      failures = 0;
  int      send_idle_pct = 0;
  int      take_stall_pct = 0;

  combinatorial_number_unit_top uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .operand_n(operand_n), .operand_k(operand_k),
    .out_valid(out_valid), .out_ready(out_ready), .value(value), .status(status)
  );

  always #6 clk = ~clk;

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic answer_t compute_number(logic [2:0] kind, logic [4:0] n, logic [4:0] k);
    logic [127:0] wide;
    logic [63:0]  v;
    logic [63:0]  row[0:31];
    bit           oflow[0:31];
    bit           o;
    bit           ovf;
    logic [1:0]   st;
    answer_t      r;
    v = 0;
    ovf = 0;
    st = cnu_pkg::ST_OK;
    if (kind > cnu_pkg::REQ_BELL) begin
      st = cnu_pkg::ST_INVALID;
    end else if (kind == cnu_pkg::REQ_POW) begin
      v = 1;
      for (int i = 0; i < k && !ovf; i++) begin
        wide = v * n;
        if (wide[127:64] != 0) ovf = 1; else v = wide[63:0];
      end
    end else if (kind == cnu_pkg::REQ_ARR || kind == cnu_pkg::REQ_COMB) begin
      if (k > n) begin
        st = cnu_pkg::ST_INVALID;
      end else begin
        v = 1;
        for (int i = 0; i < k && !ovf; i++) begin
          wide = v * (n - i);
          if (wide[127:64] != 0) ovf = 1;
          else v = (kind == cnu_pkg::REQ_COMB) ? wide[63:0] / (i + 1) : wide[63:0];
        end
      end
    end else if (kind == cnu_pkg::REQ_PERM) begin
      v = 1;
      for (int i = 2; i <= n && !ovf; i++) begin
        wide = v * i;
        if (wide[127:64] != 0) ovf = 1; else v = wide[63:0];
      end
    end else begin
      for (int j = 0; j < 32; j++) begin
        row[j] = 0;
        oflow[j] = 0;
      end
      row[0] = 1;
      for (int i = 1; i <= n; i++) begin
        for (int j = i; j >= 1; j--) begin
          o = oflow[j-1] || oflow[j];
          wide = row[j] * j;
          if (wide[127:64] != 0) o = 1;
          wide = wide[63:0] + row[j-1];
          if (wide[127:64] != 0) o = 1;
          row[j] = o ? 64'd0 : wide[63:0];
          oflow[j] = o;
        end
        row[0] = 0;
        oflow[0] = 0;
      end
      if (kind == cnu_pkg::REQ_STIR) begin
        if (k <= n) begin
          ovf = oflow[k];
          v = row[k];
        end
      end else begin
        for (int i = 0; i <= n && !ovf; i++) begin
          if (oflow[i]) begin
            ovf = 1;
          end else begin
            wide = v + row[i];
            if (wide[127:64] != 0) ovf = 1; else v = wide[63:0];
          end
        end
      end
    end
    if (ovf && st == cnu_pkg::ST_OK) st = cnu_pkg::ST_OVF;
    if (st != cnu_pkg::ST_OK) v = 0;
    r.val = v;
    r.st = st;
    return r;
  endfunction

  task automatic send_request(logic [2:0] kind, logic [4:0] n, logic [4:0] k);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    operand_n <= n;
    operand_k <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      answers_pending = {answers_pending, compute_number(req_type, operand_n, operand_k)};
    end
    if (!rst && out_valid && out_ready) begin
      if (answers_pending.size() == 0) begin
        $error("unexpected item: value %0d status %0d", value, status);
        failures++;
      end else begin
        answer_t e;
        e = answers_pending.pop_front();
        if (value !== e.val) begin
          $error("value: expected %0d, got %0d", e.val, value);
          failures++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          failures++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !(take_stall_pct > 0 && $urandom_range(99) < take_stall_pct);
  end

  request_row_t directed[$] = '{
    '{cnu_pkg::REQ_POW,  5'd0,  5'd0,  1, 64'd1, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_POW,  5'd31, 5'd31, 1, 64'd0, cnu_pkg::ST_OVF},
    '{cnu_pkg::REQ_POW,  5'd0,  5'd31, 1, 64'd0, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_POW,  5'd2,  5'd31, 0, 0, 0},
    '{cnu_pkg::REQ_ARR,  5'd0,  5'd0,  1, 64'd1, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_ARR,  5'd3,  5'd4,  1, 64'd0, cnu_pkg::ST_INVALID},
    '{cnu_pkg::REQ_ARR,  5'd31, 5'd31, 1, 64'd0, cnu_pkg::ST_OVF},
    '{cnu_pkg::REQ_PERM, 5'd0,  5'd7,  1, 64'd1, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_PERM, 5'd20, 5'd0,  0, 0, 0},
    '{cnu_pkg::REQ_PERM, 5'd21, 5'd0,  1, 64'd0, cnu_pkg::ST_OVF},
    '{cnu_pkg::REQ_COMB, 5'd31, 5'd0,  1, 64'd1, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_COMB, 5'd0,  5'd31, 1, 64'd0, cnu_pkg::ST_INVALID},
    '{cnu_pkg::REQ_COMB, 5'd31, 5'd15, 0, 0, 0},
    '{cnu_pkg::REQ_STIR, 5'd0,  5'd0,  1, 64'd1, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_STIR, 5'd5,  5'd0,  1, 64'd0, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_STIR, 5'd3,  5'd9,  1, 64'd0, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_STIR, 5'd31, 5'd31, 1, 64'd1, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_STIR, 5'd31, 5'd10, 0, 0, 0},
    '{cnu_pkg::REQ_BELL, 5'd0,  5'd0,  1, 64'd1, cnu_pkg::ST_OK},
    '{cnu_pkg::REQ_BELL, 5'd31, 5'd31, 0, 0, 0},
    '{cnu_pkg::REQ_BELL, 5'd10, 5'd0,  0, 0, 0},
    '{3'd6,              5'd4,  5'd2,  1, 64'd0, cnu_pkg::ST_INVALID},
    '{3'd7,              5'd31, 5'd31, 1, 64'd0, cnu_pkg::ST_INVALID}
  };

  initial begin
    logic [4:0] n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      answer_t p;
      p = compute_number(directed[i].kind, directed[i].n, directed[i].k);
      if (directed[i].known && (p.val !== directed[i].val || p.st !== directed[i].st)) begin
        $error("table row %0d: predictor gives %0d/%0d", i, p.val, p.st);
        failures++;
      end
      send_request(directed[i].kind, directed[i].n, directed[i].k);
    end
    for (int i = 0; i < 600; i++) begin
      case (i / 150)
        0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
        1: begin send_idle_pct = 48; take_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  take_stall_pct = 48; end
        default: begin send_idle_pct = 35; take_stall_pct = 35; end
      endcase
      // mostly small n keeps the triangle requests short
      n = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(12));
      send_request(3'($urandom_range(7)), n,
                   ($urandom_range(1) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(n)));
    end
    in_valid <= 1'b0;
    while (answers_pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
